@@ hw/rtl/dtoc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dtoc_pkg;

  localparam int COMP_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  localparam int SW = 32;  // normalised magnitude
  localparam int CW = 36;  // cordic x/y
  localparam int AW = 26;  // angle, degrees Q.16
  localparam int DW = 28;  // doubled azimuth

  localparam int DEG90_Q16    = 90 * 65536;
  localparam int DEG180_Q16   = 180 * 65536;
  localparam int HUE_FULL_Q16 = 360 * 65536;
  localparam int HUE_FULL_Q8  = 360 * 256;
  localparam int SECTOR_Q8    = 60 * 256;
  localparam int SAT_ONE      = 65536;
  localparam int SAT_ROUND    = 45;
  localparam int SAT_RECIP    = 11930465;  // ceil(2^30 / 90)
  localparam int SAT_SHIFT    = 30;
  localparam int MID_BIAS     = 15 * 33554432;
  localparam int MID_RECIP    = 4370;      // ceil(2^16 / 15)
  localparam int CH_MAX       = 255;
  localparam int CH_MAX_SQ    = 65025;

  localparam logic [2:0] REG_COLOR_MODE = 3'd0;

  localparam logic [AW-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    AW'(2949120), AW'(1740967), AW'(919879), AW'(466945), AW'(234379), AW'(117304),
    AW'(58666), AW'(29335), AW'(14668), AW'(7334), AW'(3667), AW'(1833),
    AW'(917), AW'(458), AW'(229), AW'(115), AW'(57), AW'(29),
    AW'(14), AW'(7), AW'(4), AW'(2), AW'(1), AW'(0)
  };

endpackage

`default_nettype wire

@@ hw/rtl/direction_to_orientation_color.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Direction vector to BGR colour.
// in_*  : stream of words {dir_z, dir_y, dir_x}, one vector per word.
// out_* : stream of words {red, green, blue}, one colour per input word.
// cfg_* : register port; color_mode at byte address 0 (0 = abs components,
//         1 = hue from doubled azimuth, saturation from elevation).
// A 32-stage bit-per-stage square root is followed by the elevation CORDIC,
// one iteration per stage. One word enters and one leaves every cycle while
// out_tready does not hold the pipeline.
// All stages move together; when out_tready is low with a word waiting the
// whole pipeline holds and in_tready falls, nothing dropped or repeated.
// Gaps are kept while the output waits; the pipeline moves whenever its
// last stage is empty or being taken.
// Reset clears the stage valid bits and color_mode; no clearing pass.
// The user must change color_mode only with the pipeline empty; the block does not enforce it.
module direction_to_orientation_color
  import dtoc_pkg::*;
#(
  parameter int COMP_WIDTH   = COMP_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // dir_x, dir_y, dir_z
  input  wire  [((3*COMP_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // blue, green, red
  output logic [23:0]                          out_tdata,
  input  wire                                  cfg_psel,
  input  wire                                  cfg_penable,
  input  wire                                  cfg_pwrite,
  input  wire  [2:0]                           cfg_paddr,
  input  wire  [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int W     = COMP_WIDTH;
  localparam int N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int N2W   = 2*W + 2;
  localparam int R2W   = 2*W + 18;
  localparam int LAT   = 43 + N;
  localparam int D_M0  = 31 + N;
  localparam int D_FL  = 36 + N;
  localparam int D_HUE = 33;
  localparam int D_SZ  = 34;
  localparam int HUE_ST = 5 + N;
  localparam int SAT_ST = 40 + N;

  logic              color_mode_r;
  logic [LAT:1]      vld_r;
  logic              adv;
  logic [23:0]       out_r;

  // ---------------- config ----------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_COLOR_MODE) ? {31'd0, color_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_COLOR_MODE) begin
      color_mode_r <= cfg_pwdata[0];
    end
  end

  // ---------------- flow ----------------
  assign adv        = !vld_r[LAT] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[LAT];
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-1:1], in_tvalid};
    end
  end

  // ---------------- P1: magnitudes ----------------
  logic signed [W-1:0] ix, iy, iz;
  logic [W-1:0]        ax_w, ay_w, az_w, m_w;
  logic [W-1:0]        ax1_r, ay1_r, az1_r, m1_r;
  logic                xneg1_r, yneg1_r;

  assign ix   = in_tdata[W-1:0];
  assign iy   = in_tdata[2*W-1:W];
  assign iz   = in_tdata[3*W-1:2*W];
  assign ax_w = ix[W-1] ? (~ix + 1'b1) : ix;
  assign ay_w = iy[W-1] ? (~iy + 1'b1) : iy;
  assign az_w = iz[W-1] ? (~iz + 1'b1) : iz;

  always_comb begin
    m_w = (ax_w > ay_w) ? ax_w : ay_w;
    if (m_w < az_w) m_w = az_w;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r   <= ax_w;
      ay1_r   <= ay_w;
      az1_r   <= az_w;
      m1_r    <= m_w;
      xneg1_r <= ix[W-1];
      yneg1_r <= iy[W-1];
    end
  end

  // ---------------- P2: squares, shift search ----------------
  logic [SW-1:0]  mm;
  logic [4:0]     sh_w;
  logic [2*W-1:0] c2_2_r [0:2];
  logic [W-1:0]   ax2_r, ay2_r, az2_r;
  logic [4:0]     sh2_r;
  logic           xneg2_r, yneg2_r, zero2_r, hz2_r;

  always_comb begin
    mm   = SW'(m1_r);
    sh_w = '0;
    for (int j = 4; j >= 0; j--) begin
      if (mm < (SW'(1) << (SW - 1 - (1 << j)))) begin
        mm   = mm << (1 << j);
        sh_w = sh_w + 5'(1 << j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_2_r[0] <= (2*W)'(az1_r) * (2*W)'(az1_r);
      c2_2_r[1] <= (2*W)'(ay1_r) * (2*W)'(ay1_r);
      c2_2_r[2] <= (2*W)'(ax1_r) * (2*W)'(ax1_r);
      ax2_r     <= ax1_r;
      ay2_r     <= ay1_r;
      az2_r     <= az1_r;
      sh2_r     <= sh_w;
      xneg2_r   <= xneg1_r;
      yneg2_r   <= yneg1_r;
      zero2_r   <= (m1_r == '0);
      hz2_r     <= (ax1_r == '0) && (ay1_r == '0);
    end
  end

  // ---------------- P3: sums, scaling ----------------
  logic [N2W-1:0] n2_r  [0:8];
  logic [R2W-1:0] rhs_r [0:8][0:2];
  logic [R2W-1:0] kn_r  [0:8][0:2];
  logic [7:0]     k_r   [0:8][0:2];
  logic           z0_r  [0:8];
  logic [SW-1:0]  sx3_r, sy3_r, sz3_r;
  logic           xneg3_r, yneg3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n2_r[0] <= N2W'(c2_2_r[0]) + N2W'(c2_2_r[1]) + N2W'(c2_2_r[2]);
      for (int c = 0; c < 3; c++) begin
        rhs_r[0][c] <= R2W'(c2_2_r[c]) * R2W'(CH_MAX_SQ);
        kn_r[0][c]  <= '0;
        k_r[0][c]   <= '0;
      end
      z0_r[0] <= zero2_r;
      sx3_r   <= SW'(ax2_r) << sh2_r;
      sy3_r   <= SW'(ay2_r) << sh2_r;
      sz3_r   <= SW'(az2_r) << sh2_r;
      xneg3_r <= xneg2_r;
      yneg3_r <= yneg2_r;
    end
  end

  // ---------------- P4..P11: abs channels, one bit a stage ----------------
  logic [15:0]    inc_w  [0:7][0:2];
  logic [R2W-1:0] cand_w [0:7][0:2];
  logic           take_w [0:7][0:2];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      for (int c = 0; c < 3; c++) begin
        inc_w[b][c]  = ({7'd0, k_r[b][c], 1'b0} + (16'd1 << (7 - b))) << (7 - b);
        cand_w[b][c] = kn_r[b][c] + R2W'(inc_w[b][c]) * R2W'(n2_r[b]);
        take_w[b][c] = cand_w[b][c] <= rhs_r[b][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int b = 0; b < 8; b++) begin
        n2_r[b+1] <= n2_r[b];
        z0_r[b+1] <= z0_r[b];
        for (int c = 0; c < 3; c++) begin
          rhs_r[b+1][c] <= rhs_r[b][c];
          kn_r[b+1][c]  <= take_w[b][c] ? cand_w[b][c] : kn_r[b][c];
          k_r[b+1][c]   <= take_w[b][c] ? (k_r[b][c] | (8'd1 << (7 - b))) : k_r[b][c];
        end
      end
    end
  end

  logic [23:0] m0d_r [0:D_M0-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      m0d_r[0] <= z0_r[8] ? 24'd0 : {k_r[8][2], k_r[8][1], k_r[8][0]};
      for (int i = 1; i < D_M0; i++) m0d_r[i] <= m0d_r[i-1];
    end
  end

  // ---------------- P4, P5: horizontal length squared ----------------
  logic [63:0]   sx2_r, sy2_r;
  logic [SW-1:0] szd_r [0:D_SZ-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sx2_r    <= 64'(sx3_r) * 64'(sx3_r);
      sy2_r    <= 64'(sy3_r) * 64'(sy3_r);
      szd_r[0] <= sz3_r;
      for (int i = 1; i < D_SZ; i++) szd_r[i] <= szd_r[i-1];
    end
  end

  // ---------------- P5..P37: integer square root ----------------
  logic [63:0] sq_v_r [0:32];
  logic [63:0] sq_r_r [0:32];
  logic [63:0] sq_rb_w [0:31];

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      sq_rb_w[k] = sq_r_r[k] + (64'd1 << (62 - 2*k));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v_r[0] <= sx2_r + sy2_r;
      sq_r_r[0] <= '0;
      for (int k = 0; k < 32; k++) begin
        if (sq_v_r[k] >= sq_rb_w[k]) begin
          sq_v_r[k+1] <= sq_v_r[k] - sq_rb_w[k];
          sq_r_r[k+1] <= (sq_r_r[k] >> 1) + (64'd1 << (62 - 2*k));
        end else begin
          sq_v_r[k+1] <= sq_v_r[k];
          sq_r_r[k+1] <= sq_r_r[k] >> 1;
        end
      end
    end
  end

  // ---------------- P4..P(4+N): azimuth CORDIC ----------------
  logic signed [CW-1:0] az_x_r [0:N];
  logic signed [CW-1:0] az_y_r [0:N];
  logic signed [AW-1:0] az_z_r [0:N];
  logic [1:0]           az_q_r [0:N];
  logic signed [CW-1:0] az_x_nxt [0:N-1];
  logic signed [CW-1:0] az_y_nxt [0:N-1];
  logic signed [AW-1:0] az_z_nxt [0:N-1];
  logic signed [CW-1:0] syv;

  assign syv = CW'(sy3_r);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!az_y_r[i][CW-1]) begin
        az_x_nxt[i] = az_x_r[i] + (az_y_r[i] >>> i);
        az_y_nxt[i] = az_y_r[i] - (az_x_r[i] >>> i);
        az_z_nxt[i] = az_z_r[i] + $signed(ATAN_TAB[i]);
      end else begin
        az_x_nxt[i] = az_x_r[i] - (az_y_r[i] >>> i);
        az_y_nxt[i] = az_y_r[i] + (az_x_r[i] >>> i);
        az_z_nxt[i] = az_z_r[i] - $signed(ATAN_TAB[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      az_x_r[0] <= CW'(sx3_r);
      az_y_r[0] <= (xneg3_r ^ yneg3_r) ? -syv : syv;
      az_z_r[0] <= '0;
      az_q_r[0] <= {xneg3_r, yneg3_r};
      for (int i = 0; i < N; i++) begin
        az_x_r[i+1] <= az_x_nxt[i];
        az_y_r[i+1] <= az_y_nxt[i];
        az_z_r[i+1] <= az_z_nxt[i];
        az_q_r[i+1] <= az_q_r[i];
      end
    end
  end

  // ---------------- P(5+N): hue ----------------
  logic signed [DW-1:0] off_w, hd_w;
  logic [DW-1:0]        hu_w;
  logic [16:0]          hue_w, hue_r;
  logic [16:0]          hd_r [0:D_HUE-1];

  always_comb begin
    if (az_q_r[N][1]) begin
      off_w = az_q_r[N][0] ? -DW'(DEG180_Q16) : DW'(DEG180_Q16);
    end else begin
      off_w = '0;
    end
    hd_w = ((off_w + DW'(az_z_r[N])) <<< 1) + DW'(HUE_FULL_Q16);
    if (hd_w < 0) begin
      hd_w = hd_w + DW'(HUE_FULL_Q16);
    end else if (hd_w >= DW'(2 * HUE_FULL_Q16)) begin
      hd_w = hd_w - DW'(2 * HUE_FULL_Q16);
    end else if (hd_w >= DW'(HUE_FULL_Q16)) begin
      hd_w = hd_w - DW'(HUE_FULL_Q16);
    end
    hu_w  = hd_w + DW'(128);
    hue_w = hu_w[24:8];
    if (hue_w >= 17'(HUE_FULL_Q8)) hue_w = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r    <= hue_w;
      hd_r[0]  <= hue_r;
      for (int i = 1; i < D_HUE; i++) hd_r[i] <= hd_r[i-1];
    end
  end

  // zero-vector and no-horizontal flags
  logic [1:0] fl_r [0:D_FL-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_r[0] <= {zero2_r, hz2_r};
      for (int i = 1; i < D_FL; i++) fl_r[i] <= fl_r[i-1];
    end
  end

  // ---------------- P38..P(38+N): elevation CORDIC ----------------
  logic signed [CW-1:0] el_x_r [0:N];
  logic signed [CW-1:0] el_y_r [0:N];
  logic signed [AW-1:0] el_z_r [0:N];
  logic signed [CW-1:0] el_x_nxt [0:N-1];
  logic signed [CW-1:0] el_y_nxt [0:N-1];
  logic signed [AW-1:0] el_z_nxt [0:N-1];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!el_y_r[i][CW-1]) begin
        el_x_nxt[i] = el_x_r[i] + (el_y_r[i] >>> i);
        el_y_nxt[i] = el_y_r[i] - (el_x_r[i] >>> i);
        el_z_nxt[i] = el_z_r[i] + $signed(ATAN_TAB[i]);
      end else begin
        el_x_nxt[i] = el_x_r[i] - (el_y_r[i] >>> i);
        el_y_nxt[i] = el_y_r[i] + (el_x_r[i] >>> i);
        el_z_nxt[i] = el_z_r[i] - $signed(ATAN_TAB[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      el_x_r[0] <= CW'(sq_r_r[32][31:0]);
      el_y_r[0] <= CW'(szd_r[D_SZ-1]);
      el_z_r[0] <= '0;
      for (int i = 0; i < N; i++) begin
        el_x_r[i+1] <= el_x_nxt[i];
        el_y_r[i+1] <= el_y_nxt[i];
        el_z_r[i+1] <= el_z_nxt[i];
      end
    end
  end

  // ---------------- P(39+N), P(40+N): saturation ----------------
  logic [22:0] ec_w, ns_w;
  logic [47:0] satm_r;
  logic [16:0] hue39_r;
  logic [1:0]  fl39_r;
  logic [16:0] sat_r, hue2_r;

  always_comb begin
    if (el_z_r[N][AW-1]) begin
      ec_w = '0;
    end else if (el_z_r[N] > AW'(DEG90_Q16)) begin
      ec_w = 23'(DEG90_Q16);
    end else begin
      ec_w = el_z_r[N][22:0];
    end
    ns_w = 23'(DEG90_Q16) - ec_w + 23'(SAT_ROUND);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      satm_r  <= 48'(ns_w) * 48'(SAT_RECIP);
      hue39_r <= hd_r[D_HUE-1];
      fl39_r  <= fl_r[D_FL-1];
      if (fl39_r[1]) begin
        sat_r <= 17'(SAT_ONE);
      end else if (satm_r[47:SAT_SHIFT] > 18'(SAT_ONE)) begin
        sat_r <= 17'(SAT_ONE);
      end else begin
        sat_r <= satm_r[SAT_SHIFT+16:SAT_SHIFT];
      end
      hue2_r <= (fl39_r[1] || fl39_r[0]) ? 17'd0 : hue39_r;
    end
  end

  // ---------------- P(41+N): sector and ramp ----------------
  logic [2:0]  sec_w, sec1_r, sec2_r;
  logic [16:0] base_w;
  logic [13:0] f_w, t_w;
  logic [16:0] isat_w;
  logic [30:0] pa1_r, pb1_r;
  logic [7:0]  lo1_r, lo2_r;
  logic [24:0] lo_w;

  always_comb begin
    if (hue2_r < 17'(SECTOR_Q8)) begin
      sec_w = 3'd0;
    end else if (hue2_r < 17'(2 * SECTOR_Q8)) begin
      sec_w = 3'd1;
    end else if (hue2_r < 17'(3 * SECTOR_Q8)) begin
      sec_w = 3'd2;
    end else if (hue2_r < 17'(4 * SECTOR_Q8)) begin
      sec_w = 3'd3;
    end else if (hue2_r < 17'(5 * SECTOR_Q8)) begin
      sec_w = 3'd4;
    end else begin
      sec_w = 3'd5;
    end
    base_w = 17'(sec_w) * 17'(SECTOR_Q8);
    f_w    = 14'(hue2_r - base_w);
    t_w    = sec_w[0] ? (14'(SECTOR_Q8) - f_w) : f_w;
    isat_w = 17'(SAT_ONE) - sat_r;
    lo_w   = (25'(isat_w) * 25'(CH_MAX) + 25'd32768) >> 16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sec1_r <= sec_w;
      pa1_r  <= 31'(isat_w) * 31'(SECTOR_Q8);
      pb1_r  <= 31'(sat_r) * 31'(t_w);
      lo1_r  <= lo_w[7:0];
    end
  end

  // ---------------- P(42+N): mid numerator ----------------
  logic [39:0] mn_w;
  logic [11:0] nn2_r;

  assign mn_w = (40'(pa1_r) + 40'(pb1_r)) * 40'(CH_MAX) + 40'(MID_BIAS);

  always_ff @(posedge clk) begin
    if (adv) begin
      nn2_r  <= mn_w[37:26];
      sec2_r <= sec1_r;
      lo2_r  <= lo1_r;
    end
  end

  // ---------------- P(43+N): colour select ----------------
  logic [23:0] q_w;
  logic [7:0]  mid_w;
  logic [23:0] hsv_w;

  always_comb begin
    q_w   = 24'(nn2_r) * 24'(MID_RECIP);
    mid_w = q_w[23:16];
    case (sec2_r)
      3'd0:    hsv_w = {8'(CH_MAX), mid_w, lo2_r};
      3'd1:    hsv_w = {mid_w, 8'(CH_MAX), lo2_r};
      3'd2:    hsv_w = {lo2_r, 8'(CH_MAX), mid_w};
      3'd3:    hsv_w = {lo2_r, mid_w, 8'(CH_MAX)};
      3'd4:    hsv_w = {mid_w, lo2_r, 8'(CH_MAX)};
      default: hsv_w = {8'(CH_MAX), lo2_r, mid_w};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= color_mode_r ? hsv_w : m0d_r[D_M0-1];
    end
  end

  // ---------------- checks ----------------
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n) !adv |=> $stable(vld_r))
    else $error("stage valids moved during stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted word not in first stage");

  a_hue: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[HUE_ST] |-> hue_r < 17'(HUE_FULL_Q8))
    else $error("hue out of range");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SAT_ST] |-> sat_r <= 17'(SAT_ONE))
    else $error("saturation out of range");

endmodule

`default_nettype wire
